// ===== design/gdb_pkg.sv =====
`default_nettype none

package gdb_pkg;

    typedef logic signed [27:0] lat_t;
    typedef logic signed [28:0] lon_t;
    typedef logic [25:0] dist_t;
    typedef logic [15:0] brg_t;
    typedef logic [28:0] cfg_data_t;

    typedef enum logic [1:0] {
        REG_START_LAT,
        REG_START_LON,
        REG_SAVED_LAT,
        REG_SAVED_LON
    } cfg_reg_t;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    localparam logic [29:0] COS_GAIN    = 30'd652032874;
    localparam logic [29:0] MEAN_TO_RAD = 30'd628821183;
    localparam logic [28:0] RAD_TO_CDEG = 29'd375493621;
    localparam logic [30:0] HALF_PI     = 31'd1686629713;
    localparam logic [28:0] FOLD_HALF   = 29'd180000000;
    localparam logic [28:0] FOLD_FULL   = 29'd360000000;
    localparam logic [25:0] DIST_MAX    = 26'd45000000;
    localparam logic [31:0] QTR_ANG     = 32'd589824000;
    localparam logic [31:0] THREE_QTR   = 32'd1769472000;

    // reciprocals of 3125 folded into the leg scales, exact for the input ranges
    localparam logic [63:0] LAT_RCP_W = ((64'd11112 << 41) + 64'd3124) / 64'd3125;
    localparam logic [42:0] LAT_RCP   = LAT_RCP_W[42:0];
    localparam logic [63:0] LON_RCP_W = ((64'd711168 << 42) + 64'd3124) / 64'd3125;
    localparam logic [49:0] LON_RCP   = LON_RCP_W[49:0];

    function automatic int lane_latency(int steps);
        return 40 + steps;
    endfunction

    function automatic logic [27:0] fold_abs(logic signed [28:0] s);
        logic [28:0] m;
        m = s[28] ? 29'(-s) : 29'(s);
        if (m > FOLD_HALF)
            return 28'(FOLD_FULL - m);
        return 28'(m);
    endfunction

endpackage

`default_nettype wire

// ===== design/gps_distance_bearing.sv =====
// Flat-earth distance and compass bearing from a GPS fix to two stored points.
// Configuration: write start_lat, start_lon, saved_lat, saved_lon through
// cfg_we / cfg_index / cfg_data while no fix is in flight; reset clears all
// four to zero.
// Input channel: in_valid / in_stall with cur_lat, cur_lon in microdegrees.
// A transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with distance (metres) and bearing
// (0.01 degree) to each point; one result per fix, in order.
// The cosine CORDIC, the leg multipliers and the 32-stage square root run
// in series and set the latency. Every stage is a register.
// Throughput is one fix per cycle except while out_stall holds a result.
// When out_stall holds a waiting result, the whole pipeline holds and
// in_stall rises; nothing is dropped or repeated.
// Reset empties the pipeline and clears out_valid.
`default_nettype none

module gps_distance_bearing
    import gdb_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire cfg_reg_t  cfg_index,
    input  wire cfg_data_t cfg_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire lat_t      cur_lat,
    input  wire lon_t      cur_lon,
    output logic           out_valid,
    input  wire logic      out_stall,
    output dist_t          dist_to_start,
    output brg_t           bearing_to_start,
    output dist_t          dist_to_saved,
    output brg_t           bearing_to_saved
);

    localparam int LAT = lane_latency(CORDIC_STEPS);

    lat_t start_lat_reg, saved_lat_reg;
    lon_t start_lon_reg, saved_lon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_lat_reg <= '0;
            start_lon_reg <= '0;
            saved_lat_reg <= '0;
            saved_lon_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_LAT: start_lat_reg <= cfg_data[27:0];
                REG_START_LON: start_lon_reg <= cfg_data;
                REG_SAVED_LAT: saved_lat_reg <= cfg_data[27:0];
                REG_SAVED_LON: saved_lon_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    // advance unless a finished result is held
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign out_valid = vld_reg[LAT-1];

    gdb_lane #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_start (
        .clk      (clk),
        .en       (en),
        .cur_lat  (cur_lat),
        .cur_lon  (cur_lon),
        .ref_lat  (start_lat_reg),
        .ref_lon  (start_lon_reg),
        .distance (dist_to_start),
        .bearing  (bearing_to_start)
    );

    gdb_lane #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_saved (
        .clk      (clk),
        .en       (en),
        .cur_lat  (cur_lat),
        .cur_lon  (cur_lon),
        .ref_lat  (saved_lat_reg),
        .ref_lon  (saved_lon_reg),
        .distance (dist_to_saved),
        .bearing  (bearing_to_saved)
    );

endmodule

`default_nettype wire

// ===== design/gdb_lane.sv =====
`default_nettype none

module gdb_lane
    import gdb_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic  clk,
    input  wire logic  en,
    input  wire lat_t  cur_lat,
    input  wire lon_t  cur_lon,
    input  wire lat_t  ref_lat,
    input  wire lon_t  ref_lon,
    output dist_t      distance,
    output brg_t       bearing
);

    localparam int N   = CORDIC_STEPS;
    localparam int PAD = lane_latency(N) - (8 + 2 * N);

    lat_t la_reg, rla_reg;
    lon_t lo_reg, rlo_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la_reg  <= cur_lat;
            lo_reg  <= cur_lon;
            rla_reg <= ref_lat;
            rlo_reg <= ref_lon;
        end
    end

    logic signed [28:0] sum_m, sum_c, dla;
    logic signed [29:0] dlo;

    assign sum_m = 29'(la_reg) + 29'(rla_reg);
    assign sum_c = 29'(la_reg) + 29'(la_reg);
    assign dla   = 29'(la_reg) - 29'(rla_reg);
    assign dlo   = 30'(lo_reg) - 30'(rlo_reg);

    logic [27:0] s_reg [2];
    logic [28:0] dlat_reg;
    logic [29:0] dlon_reg;
    logic [1:0]  quad_dly_reg [6 + 2 * N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0]        <= fold_abs(sum_m);
            s_reg[1]        <= fold_abs(sum_c);
            dlat_reg        <= dla[28] ? 29'(-dla) : 29'(dla);
            dlon_reg        <= dlo[29] ? 30'(-dlo) : 30'(dlo);
            quad_dly_reg[0] <= {la_reg > rla_reg, lo_reg >= rlo_reg};
            for (int q = 1; q < 6 + 2 * N; q++)
                quad_dly_reg[q] <= quad_dly_reg[q - 1];
        end
    end

    logic [57:0] zp_m, zp_c;
    assign zp_m = s_reg[0] * MEAN_TO_RAD;
    assign zp_c = s_reg[1] * MEAN_TO_RAD;

    logic [30:0] z0_reg [2];
    logic [50:0] pl_lo_reg;
    logic [49:0] pl_hi_reg;
    logic [54:0] pn_lo_reg, pn_hi_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg[0] <= zp_m[56:26];
            z0_reg[1] <= zp_c[56:26];
            pl_lo_reg <= dlat_reg * LAT_RCP[21:0];
            pl_hi_reg <= dlat_reg * LAT_RCP[42:22];
            pn_lo_reg <= dlon_reg * LON_RCP[24:0];
            pn_hi_reg <= dlon_reg * LON_RCP[49:25];
        end
    end

    logic [71:0] lat_sum;
    logic [79:0] lon_sum;
    assign lat_sum = (72'(pl_hi_reg) << 22) + 72'(pl_lo_reg);
    assign lon_sum = (80'(pn_hi_reg) << 25) + 80'(pn_lo_reg);

    logic [29:0] a_dly_reg  [N + 1];
    logic [36:0] b0_dly_reg [N + 1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dly_reg[0]  <= lat_sum[70:41];
            b0_dly_reg[0] <= lon_sum[78:42];
            for (int d = 1; d <= N; d++)
            begin
                a_dly_reg[d]  <= a_dly_reg[d - 1];
                b0_dly_reg[d] <= b0_dly_reg[d - 1];
            end
        end
    end

    // rotation CORDIC: cosine of mean latitude and of current latitude
    logic signed [33:0] cx_reg [2][N];
    logic signed [33:0] cy_reg [2][N];
    logic signed [32:0] cz_reg [2][N];

    for (genvar k = 0; k < 2; k++)
    begin : g_cos
        for (genvar i = 0; i < N; i++)
        begin : g_step
            localparam logic signed [32:0] AT = 33'(ATAN_TAB[i]);
            logic signed [33:0] sx, sy;
            logic signed [32:0] sz;
            if (i == 0)
            begin : g_first
                assign sx = 34'(COS_GAIN);
                assign sy = '0;
                assign sz = $signed({2'b00, z0_reg[k]});
            end
            else
            begin : g_next
                assign sx = cx_reg[k][i - 1];
                assign sy = cy_reg[k][i - 1];
                assign sz = cz_reg[k][i - 1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!sz[32])
                    begin
                        cx_reg[k][i] <= sx - (sy >>> i);
                        cy_reg[k][i] <= sy + (sx >>> i);
                        cz_reg[k][i] <= sz - AT;
                    end
                    else
                    begin
                        cx_reg[k][i] <= sx + (sy >>> i);
                        cy_reg[k][i] <= sy - (sx >>> i);
                        cz_reg[k][i] <= sz + AT;
                    end
                end
            end
        end
    end

    logic [24:0] c_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                if (cx_reg[k][N - 1][33])
                    c_reg[k] <= '0;
                else if (cx_reg[k][N - 1] > 34'sd1073741824)
                    c_reg[k] <= 25'd16777216;
                else
                    c_reg[k] <= cx_reg[k][N - 1][30:6];
            end
        end
    end

    logic [61:0] bdp, bbp;
    assign bdp = b0_dly_reg[N] * c_reg[0];
    assign bbp = b0_dly_reg[N] * c_reg[1];

    logic [29:0] a5_reg;
    logic [30:0] bd_reg, bb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a5_reg <= a_dly_reg[N];
            bd_reg <= bdp[60:30];
            bb_reg <= bbp[60:30];
        end
    end

    logic [59:0] sqa_reg;
    logic [61:0] sqb_reg;
    logic [24:0] leg_lat_reg;
    logic [25:0] leg_lon_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqa_reg     <= a5_reg * a5_reg;
            sqb_reg     <= bd_reg * bd_reg;
            leg_lat_reg <= a5_reg[29:5];
            leg_lon_reg <= bb_reg[30:5];
        end
    end

    logic [62:0] v_reg;
    logic [1:0]  zf_dly_reg [N + 1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg         <= 63'(sqa_reg) + 63'(sqb_reg);
            zf_dly_reg[0] <= {leg_lat_reg == '0, leg_lon_reg == '0};
            for (int d = 1; d <= N; d++)
                zf_dly_reg[d] <= zf_dly_reg[d - 1];
        end
    end

    // integer square root, one result bit per stage
    logic [63:0] sq_rem_reg  [32];
    logic [63:0] sq_root_reg [32];

    for (genvar j = 0; j < 32; j++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'(1) << (2 * (31 - j));
        logic [63:0] srem, sroot;
        if (j == 0)
        begin : g_first
            assign srem  = {1'b0, v_reg};
            assign sroot = '0;
        end
        else
        begin : g_next
            assign srem  = sq_rem_reg[j - 1];
            assign sroot = sq_root_reg[j - 1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (srem >= sroot + BIT)
                begin
                    sq_rem_reg[j]  <= srem - (sroot + BIT);
                    sq_root_reg[j] <= (sroot >> 1) + BIT;
                end
                else
                begin
                    sq_rem_reg[j]  <= srem;
                    sq_root_reg[j] <= sroot >> 1;
                end
            end
        end
    end

    logic [26:0] d_full;
    dist_t dist_reg;
    assign d_full = sq_root_reg[31][31:5];

    always_ff @(posedge clk)
    begin
        if (en)
            dist_reg <= (d_full > 27'(DIST_MAX)) ? DIST_MAX : d_full[25:0];
    end

    assign distance = dist_reg;

    // vectoring CORDIC: angle of the two legs
    logic signed [52:0] vx_reg [N];
    logic signed [52:0] vy_reg [N];
    logic signed [32:0] vz_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        localparam logic signed [32:0] AT = 33'(ATAN_TAB[i]);
        logic signed [52:0] sx, sy;
        logic signed [32:0] sz;
        if (i == 0)
        begin : g_first
            assign sx = $signed({3'b000, leg_lon_reg, 24'd0});
            assign sy = $signed({4'b0000, leg_lat_reg, 24'd0});
            assign sz = '0;
        end
        else
        begin : g_next
            assign sx = vx_reg[i - 1];
            assign sy = vy_reg[i - 1];
            assign sz = vz_reg[i - 1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!sy[52])
                begin
                    vx_reg[i] <= sx + (sy >>> i);
                    vy_reg[i] <= sy - (sx >>> i);
                    vz_reg[i] <= sz + AT;
                end
                else
                begin
                    vx_reg[i] <= sx - (sy >>> i);
                    vy_reg[i] <= sy + (sx >>> i);
                    vz_reg[i] <= sz - AT;
                end
            end
        end
    end

    logic [30:0] zc;
    logic [59:0] ap;

    always_comb
    begin
        if (vz_reg[N - 1][32])
            zc = '0;
        else if (vz_reg[N - 1] > $signed({2'b00, HALF_PI}))
            zc = HALF_PI;
        else
            zc = vz_reg[N - 1][30:0];
    end

    assign ap = zc * RAD_TO_CDEG;

    logic [29:0] alpha_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            alpha_reg <= ap[59:30];
    end

    logic [31:0] alpha_f, cap;
    logic        q_gt, q_ge;

    assign q_gt = quad_dly_reg[5 + 2 * N][1];
    assign q_ge = quad_dly_reg[5 + 2 * N][0];

    always_comb
    begin
        if (zf_dly_reg[N][0])
            alpha_f = QTR_ANG;
        else if (zf_dly_reg[N][1])
            alpha_f = '0;
        else if (32'(alpha_reg) > QTR_ANG)
            alpha_f = QTR_ANG;
        else
            alpha_f = 32'(alpha_reg);

        if (q_gt && q_ge)
            cap = THREE_QTR - alpha_f;
        else if (!q_gt && q_ge)
            cap = THREE_QTR + alpha_f;
        else if (!q_gt)
            cap = QTR_ANG - alpha_f;
        else
            cap = QTR_ANG + alpha_f;
    end

    brg_t brg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            brg_reg <= cap[31:16];
    end

    // align bearing with distance
    if (PAD == 0)
    begin : g_nopad
        assign bearing = brg_reg;
    end
    else
    begin : g_pad
        brg_t brg_pad_reg [PAD];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                brg_pad_reg[0] <= brg_reg;
                for (int d = 1; d < PAD; d++)
                    brg_pad_reg[d] <= brg_pad_reg[d - 1];
            end
        end
        assign bearing = brg_pad_reg[PAD - 1];
    end

endmodule

`default_nettype wire
